>>> rtl/dqpi_pkg.sv
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared widths, register indexes and payload types of the d/q current PI
// controller.
// ----------------------------------------------------------------------------
package dqpi_pkg;

    localparam int DATA_W             = 16;
    localparam int GAIN_W             = 16;
    localparam int LIMIT_W            = 15;
    localparam int CFG_ADDR_W         = 4;
    localparam int CFG_DATA_W         = 16;
    localparam int CHUNK_W            = 16;
    localparam int GAIN_FRAC_BITS_DEF = 12;
    localparam int ACC_WIDTH_DEF      = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_KP_D    = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_D    = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KC_D    = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KP_Q    = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_Q    = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_KC_Q    = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_D = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_Q = 4'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] id_ref;
        logic signed [DATA_W-1:0] id_meas;
        logic signed [DATA_W-1:0] iq_ref;
        logic signed [DATA_W-1:0] iq_meas;
    } dqpi_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] ud;
        logic signed [DATA_W-1:0] uq;
        logic                     d_limited;
        logic                     q_limited;
    } dqpi_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_d;
        logic [GAIN_W-1:0]  ki_d;
        logic [GAIN_W-1:0]  kc_d;
        logic [GAIN_W-1:0]  kp_q;
        logic [GAIN_W-1:0]  ki_q;
        logic [GAIN_W-1:0]  kc_q;
        logic [LIMIT_W-1:0] limit_d;
        logic [LIMIT_W-1:0] limit_q;
    } dqpi_cfg_t;

endpackage

>>> rtl/dq_current_pi_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// dq_current_pi_antiwindup_unit
// d/q current PI controllers with output clamp and back-calculation
// anti-windup, sharing one chunked multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one item with both axes' reference and
//   measured currents; m_valid/m_ready/m_data give the clamped d and q
//   commands with their clamp flags, one result per item.
//   cfg_valid/cfg_ready/cfg_addr/cfg_data write the gains and limits; write
//   them only while no item is in flight. cfg_ready is always high.
//   Each axis takes three multiplies (kp*err, ki*err, kc*excess) in the one
//   shared multiplier, which works through NCH = ceil(UW/16) chunks of the
//   operand, UW = max(ACC_WIDTH, 33) + 1. An item runs the d axis and then
//   the q axis before m_valid is raised; a new item is accepted only after
//   the last one has left the sequencer. s_ready is high only between items.
//   The next item is accepted while a result still waits in the output
//   register; if the receiver stalls, the block finishes that next item
//   and then holds until the waiting result is taken.
//   Reset clears both integrators, zeroes the gains and sets the limits to
//   full scale.
// ----------------------------------------------------------------------------
module dq_current_pi_antiwindup_unit
    import dqpi_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int ACC_WIDTH      = ACC_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dqpi_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dqpi_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int EW  = DATA_W + 1;
    localparam int PW0 = EW + GAIN_W;
    localparam int UW  = ((ACC_WIDTH > PW0) ? ACC_WIDTH : PW0) + 1;
    localparam int MPW = UW + GAIN_W;
    localparam int SW  = MPW + 1;

    localparam logic [31:0] DMAX32 = 32'((64'd1 << (DATA_W - 1)) - 64'd1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MKP  = 4'd1;
    localparam logic [3:0] S_WKP  = 4'd2;
    localparam logic [3:0] S_LIM  = 4'd3;
    localparam logic [3:0] S_EXC  = 4'd4;
    localparam logic [3:0] S_WKI  = 4'd5;
    localparam logic [3:0] S_MKC  = 4'd6;
    localparam logic [3:0] S_WKC  = 4'd7;
    localparam logic [3:0] S_SAT  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    dqpi_cfg_t cfg;

    logic [3:0]                  state_reg, state_next;
    logic                        sel_reg, sel_next;
    logic                        m_valid_reg, m_valid_next;
    dqpi_in_t                    in_reg, in_next;
    dqpi_out_t                   out_reg, out_next;
    logic signed [ACC_WIDTH-1:0] integ_d_reg, integ_d_next;
    logic signed [ACC_WIDTH-1:0] integ_q_reg, integ_q_next;
    logic signed [UW-1:0]        u_reg, u_next;
    logic signed [UW-1:0]        c_reg, c_next;
    logic signed [UW-1:0]        exc_reg, exc_next;
    logic                        flag_reg, flag_next;
    logic signed [SW-1:0]        acc_reg, acc_next;
    logic signed [DATA_W-1:0]    ud_reg, ud_next;
    logic                        dl_reg, dl_next;

    logic                        mul_start;
    logic [GAIN_W-1:0]           mul_gain;
    logic signed [UW-1:0]        mul_op;
    logic                        mul_done;
    logic signed [MPW-1:0]       mul_prod;

    logic signed [EW-1:0]        err;
    logic signed [ACC_WIDTH-1:0] integ_cur;
    logic [LIMIT_W-1:0]          limit_cur;
    logic [31:0]                 lim_ext, eff;
    logic signed [UW-1:0]        lims;
    logic signed [MPW-1:0]       term;
    logic signed [ACC_WIDTH-1:0] sat_val;
    logic signed [UW-1:0]        c_shift;
    logic                        ovf;

    dqpi_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dqpi_mul #(
        .OPW (UW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .gain    (mul_gain),
        .operand (mul_op),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // per-axis operands
    assign err = sel_reg ? (EW'(in_reg.iq_ref) - EW'(in_reg.iq_meas))
                         : (EW'(in_reg.id_ref) - EW'(in_reg.id_meas));
    assign integ_cur = sel_reg ? integ_q_reg : integ_d_reg;
    assign limit_cur = sel_reg ? cfg.limit_q : cfg.limit_d;

    // effective limit never exceeds the output range
    assign lim_ext = 32'(limit_cur);
    assign eff     = (lim_ext > DMAX32) ? DMAX32 : lim_ext;
    assign lims    = $signed(UW'(eff) << GAIN_FRAC_BITS);

    assign term    = mul_prod >>> GAIN_FRAC_BITS;
    assign c_shift = c_reg >>> GAIN_FRAC_BITS;

    // saturate when the bits above the integrator width disagree with its sign
    assign ovf     = !((&acc_reg[SW-1:ACC_WIDTH-1]) || !(|acc_reg[SW-1:ACC_WIDTH-1]));
    assign sat_val = ovf ? (acc_reg[SW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACC_WIDTH-1){1'b1}}})
                         : acc_reg[ACC_WIDTH-1:0];

    assign mul_start = (state_reg == S_MKP) || (state_reg == S_EXC)
                       || (state_reg == S_MKC);

    always_comb begin
        mul_gain = sel_reg ? cfg.kp_q : cfg.kp_d;
        mul_op   = UW'(err);
        if (state_reg == S_EXC) begin
            mul_gain = sel_reg ? cfg.ki_q : cfg.ki_d;
        end else if (state_reg == S_MKC) begin
            mul_gain = sel_reg ? cfg.kc_q : cfg.kc_d;
            mul_op   = exc_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg;
        in_next      = in_reg;
        out_next     = out_reg;
        integ_d_next = integ_d_reg;
        integ_q_next = integ_q_reg;
        u_next       = u_reg;
        c_next       = c_reg;
        exc_next     = exc_reg;
        flag_next    = flag_reg;
        acc_next     = acc_reg;
        ud_next      = ud_reg;
        dl_next      = dl_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    sel_next   = 1'b0;
                    state_next = S_MKP;
                end
            end
            S_MKP: begin
                state_next = S_WKP;
            end
            S_WKP: begin
                if (mul_done) begin
                    u_next     = UW'(integ_cur) + mul_prod[UW-1:0];
                    state_next = S_LIM;
                end
            end
            S_LIM: begin
                priority if (u_reg > lims) begin
                    c_next    = lims;
                    flag_next = 1'b1;
                end else if (u_reg < -lims) begin
                    c_next    = -lims;
                    flag_next = 1'b1;
                end else begin
                    c_next    = u_reg;
                    flag_next = 1'b0;
                end
                state_next = S_EXC;
            end
            S_EXC: begin
                exc_next   = u_reg - c_reg;
                state_next = S_WKI;
            end
            S_WKI: begin
                if (mul_done) begin
                    acc_next   = SW'(integ_cur) + SW'(mul_prod);
                    state_next = S_MKC;
                end
            end
            S_MKC: begin
                state_next = S_WKC;
            end
            S_WKC: begin
                if (mul_done) begin
                    acc_next   = acc_reg - SW'(term);
                    state_next = S_SAT;
                end
            end
            S_SAT: begin
                if (sel_reg) begin
                    integ_q_next = sat_val;
                    state_next   = S_DONE;
                end else begin
                    integ_d_next = sat_val;
                    ud_next      = c_shift[DATA_W-1:0];
                    dl_next      = flag_reg;
                    sel_next     = 1'b1;
                    state_next   = S_MKP;
                end
            end
            S_DONE: begin
                // hold until the previous result has left
                if (!m_valid_reg || m_ready) begin
                    out_next.ud        = ud_reg;
                    out_next.d_limited = dl_reg;
                    out_next.uq        = c_shift[DATA_W-1:0];
                    out_next.q_limited = flag_reg;
                    m_valid_next       = 1'b1;
                    sel_next           = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            integ_d_reg <= '0;
            integ_q_reg <= '0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
            integ_d_reg <= integ_d_next;
            integ_q_reg <= integ_q_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        out_reg  <= out_next;
        u_reg    <= u_next;
        c_reg    <= c_next;
        exc_reg  <= exc_next;
        flag_reg <= flag_next;
        acc_reg  <= acc_next;
        ud_reg   <= ud_next;
        dl_reg   <= dl_next;
    end

    // multiplier results only arrive while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_WKP || state_reg == S_WKI || state_reg == S_WKC))
        else $error("multiplier done outside a wait state");

    // an accepted item always starts on the d axis
    a_accept_starts_d: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_MKP && !sel_reg))
        else $error("item did not start on the d axis");

    // a result is loaded only from the final state after the q axis
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> sel_reg)
        else $error("done reached before the q axis");

    // the d-axis integrator only changes at the end of a d-axis pass
    a_integ_d_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(integ_d_reg) |-> ($past(state_reg) == S_SAT && !$past(sel_reg)))
        else $error("d integrator changed outside its update");

endmodule

>>> rtl/dqpi_cfg_regs.sv
// ----------------------------------------------------------------------------
// dqpi_cfg_regs
// Gain and limit register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module dqpi_cfg_regs
    import dqpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dqpi_cfg_t             cfg
);

    dqpi_cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                REG_KP_D:    cfg_next.kp_d    = cfg_data[GAIN_W-1:0];
                REG_KI_D:    cfg_next.ki_d    = cfg_data[GAIN_W-1:0];
                REG_KC_D:    cfg_next.kc_d    = cfg_data[GAIN_W-1:0];
                REG_KP_Q:    cfg_next.kp_q    = cfg_data[GAIN_W-1:0];
                REG_KI_Q:    cfg_next.ki_q    = cfg_data[GAIN_W-1:0];
                REG_KC_Q:    cfg_next.kc_q    = cfg_data[GAIN_W-1:0];
                REG_LIMIT_D: cfg_next.limit_d = cfg_data[LIMIT_W-1:0];
                REG_LIMIT_Q: cfg_next.limit_q = cfg_data[LIMIT_W-1:0];
                default: begin
                    // unused index, write dropped
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_d    <= '0;
            cfg_reg.ki_d    <= '0;
            cfg_reg.kc_d    <= '0;
            cfg_reg.kp_q    <= '0;
            cfg_reg.ki_q    <= '0;
            cfg_reg.kc_q    <= '0;
            cfg_reg.limit_d <= LIMIT_RESET;
            cfg_reg.limit_q <= LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/dqpi_mul.sv
// ----------------------------------------------------------------------------
// dqpi_mul
// Shared multiplier: unsigned gain times signed operand, one 16-bit chunk of
// the operand magnitude per cycle, most significant chunk first.
// ----------------------------------------------------------------------------
module dqpi_mul
    import dqpi_pkg::*;
#(
    parameter int OPW = 34
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [GAIN_W-1:0]             gain,
    input  logic signed [OPW-1:0]         operand,
    output logic                          done,
    output logic signed [OPW+GAIN_W-1:0]  product
);

    localparam int NCH  = (OPW + CHUNK_W - 1) / CHUNK_W;
    localparam int MAGW = NCH * CHUNK_W;
    localparam int AW   = MAGW + GAIN_W;
    localparam int PRW  = OPW + GAIN_W;
    localparam int CW   = $clog2(NCH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [MAGW-1:0]       mag_reg, mag_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [GAIN_W-1:0]     gain_reg, gain_next;
    logic signed [PRW-1:0] prod_reg, prod_next;

    logic [OPW-1:0]               op_mag;
    logic [GAIN_W+CHUNK_W-1:0]    part;

    assign op_mag = operand[OPW-1] ? OPW'(-operand) : OPW'(operand);
    assign part   = gain_reg * mag_reg[MAGW-1 -: CHUNK_W];

    assign done    = done_reg;
    assign product = prod_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        gain_next = gain_reg;
        prod_next = prod_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NCH);
            mag_next  = MAGW'(op_mag);
            acc_next  = '0;
            neg_next  = operand[OPW-1];
            gain_next = gain;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                acc_next = (acc_reg << CHUNK_W) + AW'(part);
                mag_next = mag_reg << CHUNK_W;
                cnt_next = cnt_reg - 1'b1;
            end else begin
                // apply the operand sign to the finished magnitude
                prod_next = neg_reg ? -$signed(acc_reg[PRW-1:0])
                                    : $signed(acc_reg[PRW-1:0]);
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        gain_reg <= gain_next;
        prod_reg <= prod_next;
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the d/q current PI controller. Drives current items
// with random gaps, predicts the clamped commands and flags of both axes from
// an independent integrator model, and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import dqpi_pkg::*;

    localparam longint ACC_MAX   = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
    localparam int     STALL_LEN = 400;
    localparam int     IDLE_PCT  = 13;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    dqpi_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    dqpi_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    dqpi_cfg_t ctl_cfg;
    longint    integ_d;
    longint    integ_q;
    dqpi_out_t cmd_queue[$];

    int bad_cmds = 0;
    int cmd_seen = 0;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit stall_tgl    = 1'b0;
    bit stall_seen   = 1'b0;
    int hold_left    = 0;

    dq_current_pi_antiwindup_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // one axis: drive, clamp, back-calculated integrator update
    function automatic logic signed [DATA_W-1:0] axis_update(
        inout  longint                    integ,
        input  logic [GAIN_W-1:0]         kp,
        input  logic [GAIN_W-1:0]         ki,
        input  logic [GAIN_W-1:0]         kc,
        input  logic [LIMIT_W-1:0]        lim,
        input  logic signed [DATA_W-1:0]  ref_i,
        input  logic signed [DATA_W-1:0]  meas_i,
        output logic                      clamped
    );
        longint err, span, drive, held, acc;
        err     = longint'(ref_i) - longint'(meas_i);
        span    = longint'(lim) <<< GAIN_FRAC_BITS_DEF;
        drive   = integ + longint'(kp) * err;
        held    = drive;
        clamped = 1'b0;
        if (drive > span) begin
            held    = span;
            clamped = 1'b1;
        end else if (drive < -span) begin
            held    = -span;
            clamped = 1'b1;
        end
        // excess term floors toward minus infinity
        acc = integ + longint'(ki) * err
              - ((longint'(kc) * (drive - held)) >>> GAIN_FRAC_BITS_DEF);
        if (acc > ACC_MAX)
            acc = ACC_MAX;
        else if (acc < -ACC_MAX - 1)
            acc = -ACC_MAX - 1;
        integ = acc;
        return DATA_W'(held >>> GAIN_FRAC_BITS_DEF);
    endfunction

    function automatic dqpi_out_t pi_step(input dqpi_in_t it);
        dqpi_out_t r;
        logic      dl, ql;
        r.ud = axis_update(integ_d, ctl_cfg.kp_d, ctl_cfg.ki_d, ctl_cfg.kc_d,
                           ctl_cfg.limit_d, it.id_ref, it.id_meas, dl);
        r.uq = axis_update(integ_q, ctl_cfg.kp_q, ctl_cfg.ki_q, ctl_cfg.kc_q,
                           ctl_cfg.limit_q, it.iq_ref, it.iq_meas, ql);
        r.d_limited = dl;
        r.q_limited = ql;
        return r;
    endfunction

    function automatic dqpi_in_t dq(input int a, input int b, input int c, input int d);
        dqpi_in_t it;
        it.id_ref  = DATA_W'(a);
        it.id_meas = DATA_W'(b);
        it.iq_ref  = DATA_W'(c);
        it.iq_meas = DATA_W'(d);
        return it;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_current();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // measured value tracks the setpoint in half the draws so the loop leaves saturation
    function automatic logic signed [DATA_W-1:0] paired_meas(
        input logic signed [DATA_W-1:0] r
    );
        int delta;
        delta = int'($urandom_range(256)) - 128;
        case ($urandom_range(3))
            0:       return r + DATA_W'(delta);
            1:       return r;
            default: return rand_current();
        endcase
    endfunction

    function automatic dqpi_in_t random_item();
        dqpi_in_t it;
        it.id_ref  = rand_current();
        it.id_meas = paired_meas(it.id_ref);
        it.iq_ref  = rand_current();
        it.iq_meas = paired_meas(it.iq_ref);
        return it;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'(1 << GAIN_FRAC_BITS_DEF);
            3:       return GAIN_W'($urandom_range(8191));
            4:       return GAIN_W'($urandom_range(1023));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return LIMIT_W'($urandom_range(2000));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    function automatic dqpi_cfg_t random_cfg();
        dqpi_cfg_t c;
        c.kp_d    = pick_gain();
        c.ki_d    = pick_gain();
        c.kc_d    = pick_gain();
        c.kp_q    = pick_gain();
        c.ki_q    = pick_gain();
        c.kc_q    = pick_gain();
        c.limit_d = pick_limit();
        c.limit_q = pick_limit();
        return c;
    endfunction

    // receiver side: random idling plus one long hold-off on request
    always @(posedge aclk) begin
        if (stall_tgl != stall_seen) begin
            stall_seen <= stall_tgl;
            hold_left  <= STALL_LEN;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        dqpi_out_t want;
        if (aresetn && m_valid && m_ready) begin
            cmd_seen++;
            if (cmd_queue.size() == 0) begin
                bad_cmds++;
                if (bad_cmds <= 10)
                    $display("unexpected item %0d: ud=%0d uq=%0d dl=%0b ql=%0b",
                             cmd_seen, m_data.ud, m_data.uq, m_data.d_limited,
                             m_data.q_limited);
            end else begin
                want = cmd_queue.pop_front();
                if (m_data.ud !== want.ud || m_data.uq !== want.uq ||
                    m_data.d_limited !== want.d_limited ||
                    m_data.q_limited !== want.q_limited) begin
                    bad_cmds++;
                    if (bad_cmds <= 10)
                        $display("item %0d: expected ud=%0d uq=%0d dl=%0b ql=%0b, got ud=%0d uq=%0d dl=%0b ql=%0b",
                                 cmd_seen, want.ud, want.uq, want.d_limited,
                                 want.q_limited, m_data.ud, m_data.uq,
                                 m_data.d_limited, m_data.q_limited);
                end
            end
        end
    end

    task automatic send_item(input dqpi_in_t it);
        if (src_idle_on)
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        cmd_queue.push_back(pi_step(it));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_KP_D:    ctl_cfg.kp_d    = val;
            REG_KI_D:    ctl_cfg.ki_d    = val;
            REG_KC_D:    ctl_cfg.kc_d    = val;
            REG_KP_Q:    ctl_cfg.kp_q    = val;
            REG_KI_Q:    ctl_cfg.ki_q    = val;
            REG_KC_Q:    ctl_cfg.kc_q    = val;
            REG_LIMIT_D: ctl_cfg.limit_d = val[LIMIT_W-1:0];
            REG_LIMIT_Q: ctl_cfg.limit_q = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input dqpi_cfg_t c);
        wait_idle();
        write_reg(REG_KP_D, c.kp_d);
        write_reg(REG_KI_D, c.ki_d);
        write_reg(REG_KC_D, c.kc_d);
        write_reg(REG_KP_Q, c.kp_q);
        write_reg(REG_KI_Q, c.ki_q);
        write_reg(REG_KC_Q, c.kc_q);
        // top data bit is outside the limit field and must be dropped
        write_reg(REG_LIMIT_D, {1'($urandom), c.limit_d});
        write_reg(REG_LIMIT_Q, {1'($urandom), c.limit_q});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_item(dq(32767, -32768, -32768, 32767));
        send_item(dq(0, 0, 0, 0));
    endtask

    task automatic test_unused_index();
        wait_idle();
        for (int i = int'(REG_LIMIT_Q) + 1; i < (1 << CFG_ADDR_W); i++)
            write_reg(CFG_ADDR_W'(i), '1);
        cfg_valid <= 1'b0;
        send_item(dq(32767, -32768, 1000, -1000));
    endtask

    task automatic test_clamp_edges();
        dqpi_cfg_t c;
        c = '{kp_d: 16'd4096, ki_d: 16'd0, kc_d: 16'd0,
              kp_q: 16'd4096, ki_q: 16'd0, kc_q: 16'd0,
              limit_d: 15'd100, limit_q: 15'h7FFF};
        load_config(c);
        // exactly at the limit is not clamped, one past it is
        send_item(dq(100, 0, 32767, 0));
        send_item(dq(0, 100, -32768, 0));
        send_item(dq(101, 0, 0, 32767));
        send_item(dq(-1, 100, 32767, -32768));
    endtask

    task automatic test_zero_limit();
        dqpi_cfg_t c;
        c = '{kp_d: 16'd1, ki_d: 16'd0, kc_d: 16'd0,
              kp_q: 16'd1, ki_q: 16'd0, kc_q: 16'd0,
              limit_d: 15'd0, limit_q: 15'h7FFF};
        load_config(c);
        // q axis shows the floor of a small negative drive
        send_item(dq(1, 0, -1, 0));
        send_item(dq(0, 0, 1, 0));
        send_item(dq(-1, 0, 0, 0));
    endtask

    task automatic test_integrator_saturation();
        dqpi_cfg_t c;
        c = '{kp_d: 16'd0, ki_d: 16'hFFFF, kc_d: 16'd0,
              kp_q: 16'd0, ki_q: 16'hFFFF, kc_q: 16'd0,
              limit_d: 15'h7FFF, limit_q: 15'h7FFF};
        load_config(c);
        repeat (3) send_item(dq(32767, -32768, -32768, 32767));
        repeat (3) send_item(dq(-32768, 32767, 32767, -32768));
    endtask

    task automatic test_antiwindup();
        dqpi_cfg_t c;
        c = '{kp_d: 16'd4096, ki_d: 16'd2048, kc_d: 16'hFFFF,
              kp_q: 16'd8192, ki_q: 16'd4096, kc_q: 16'd4096,
              limit_d: 15'd1000, limit_q: 15'd50};
        load_config(c);
        repeat (3) send_item(dq(20000, 0, 5000, -5000));
        repeat (2) send_item(dq(-300, 0, -100, 0));
    endtask

    task automatic test_backpressure();
        load_config(random_cfg());
        stall_tgl <= ~stall_tgl;
        repeat (40) send_item(random_item());
    endtask

    task automatic test_no_idle();
        load_config(random_cfg());
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (150) send_item(random_item());
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        dqpi_cfg_t c;
        for (int p = 0; p < 9; p++) begin
            c = random_cfg();
            if (p == 0)
                c = '1;
            else if (p == 1)
                c = '0;
            load_config(c);
            repeat (85) send_item(random_item());
        end
    endtask

    initial begin
        ctl_cfg         = '0;
        ctl_cfg.limit_d = LIMIT_RESET;
        ctl_cfg.limit_q = LIMIT_RESET;
        integ_d         = 0;
        integ_q         = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_unused_index();
        test_clamp_edges();
        test_zero_limit();
        test_integrator_saturation();
        test_antiwindup();
        test_backpressure();
        test_no_idle();
        test_random_phases();

        wait_idle();
        repeat (64) @(posedge aclk);
        if (bad_cmds == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
